### rtl/glz_pkg.sv
// Package for the GIF LZW compressor: shared constants and the sequencer state type.
// Used by the channel interfaces and by gif_lzw_compressor.
package glz_pkg;

    // Fixed field and code widths.
    localparam int CODE_W     = 12;
    localparam int SYM_W      = 8;
    localparam int PAIR_W     = CODE_W + SYM_W;
    localparam int CFG_W      = 4;
    localparam int CWIDTH_W   = 4;
    localparam int NEXT_W     = 13;
    localparam int ACC_W      = 20;
    localparam int FILL_W     = 5;

    // Defaults for the top-level parameters.
    localparam int DICT_DEPTH_DEF    = 4096;
    localparam int MAX_CODE_BITS_DEF = 12;

    // Legal range of the minimum code size.
    localparam logic [CFG_W-1:0] MIN_SIZE_LO  = 4'd2;
    localparam logic [CFG_W-1:0] MIN_SIZE_HI  = 4'd8;
    localparam logic [CFG_W-1:0] MIN_SIZE_RST = 4'd2;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PROBE_H,
        S_PROBE_D,
        S_EMIT_CLEAR,
        S_EMIT_PREFIX,
        S_EMIT_LAST,
        S_EMIT_END,
        S_FLUSH
    } glz_state_t;

endpackage

### rtl/glz_if.sv
// Valid/ready channel interfaces of the GIF LZW compressor: pixels, bytes, configuration.
// Depends on glz_pkg for the field widths.
interface glz_pix_if
    import glz_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] pixel_index;
    logic             last_pixel;

    modport source (output valid, output pixel_index, output last_pixel, input ready);
    modport sink   (input valid, input pixel_index, input last_pixel, output ready);
endinterface

interface glz_byte_if
    import glz_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [SYM_W-1:0] code_byte;
    logic             last_byte;

    modport source (output valid, output code_byte, output last_byte, input ready);
    modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

interface glz_cfg_if
    import glz_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] min_code_size;

    modport source (output valid, output min_code_size, input ready);
    modport sink   (input valid, input min_code_size, output ready);
endinterface

### rtl/gif_lzw_compressor.sv
// GIF LZW compressor: pixel stream in, LSB-first packed code bytes out.
// Depends on glz_pkg and the channel interfaces in glz_if.sv.
//
// Usage:
//   pixels : one beat per palette-index pixel, last_pixel marks the end of an image.
//   bytes  : one beat per packed code byte, last_byte marks the padded final byte.
//   cfg    : one beat writes min_code_size; it takes effect at the next image.
// Each pixel is accepted in S_IDLE, then its prefix/symbol pair is looked up in a
// hash table with linear probing. A probe reads the hash slot memory for a candidate
// code; when that code is live in this image a further step reads its dictionary
// entry, whose owning slot says whether the slot is taken and whose pair says whether
// it is a hit. A taken slot with another pair moves on to the next slot; any other
// slot ends the lookup as a miss. A typical pixel goes through accept, one probe,
// then the hit or the prefix code emitted on a miss; each further probe adds its reads.
// Each code waits until fewer than 8 bits are held in the packer, so a
// stalled byte receiver holds the sequencer once the output register and packer are full.
// The first pixel of an image emits the clear code and opens the prefix; the last adds two
// more codes and a final drain. The dictionary needs no clearing: a slot counts only
// when the code it holds is below the next free code and that code's entry names the
// same slot. Reset empties the packer and output register and waits for a first pixel;
// there is no clearing pass.
module gif_lzw_compressor
    import glz_pkg::*;
#(
    parameter int DICT_DEPTH    = DICT_DEPTH_DEF,
    parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    glz_pix_if.sink   pixels,
    glz_byte_if.source bytes,
    glz_cfg_if.sink   cfg
);

    localparam int DBITS      = $clog2(DICT_DEPTH);
    localparam int HBITS      = DBITS + 1;
    localparam int HASH_DEPTH = 2 * DICT_DEPTH;
    localparam int ENT_W      = PAIR_W + HBITS;
    localparam int LIM_RAW    = 1 << MAX_CODE_BITS;
    localparam int CODE_LIMIT = (DICT_DEPTH < LIM_RAW) ? DICT_DEPTH : LIM_RAW;
    localparam logic [NEXT_W-1:0]   LIMIT_N = NEXT_W'(CODE_LIMIT);
    localparam logic [CWIDTH_W-1:0] MAX_CW  = CWIDTH_W'(MAX_CODE_BITS);

    // Memories: hash slots hold codes, dictionary entries hold pair and owning slot.
    logic [DBITS-1:0] hash_mem [HASH_DEPTH];
    logic [ENT_W-1:0] dict_mem [DICT_DEPTH];

    glz_state_t state_reg, state_next;

    logic [CFG_W-1:0]    cfg_reg;
    logic [CFG_W-1:0]    held_reg, held_next;
    logic [NEXT_W-1:0]   next_code_reg, next_code_next;
    logic [CODE_W-1:0]   prefix_reg, prefix_next;
    logic [CWIDTH_W-1:0] width_reg, width_next;
    logic                in_image_reg, in_image_next;
    logic [SYM_W-1:0]    sym_reg, sym_next;
    logic                last_reg, last_next;
    logic [HBITS-1:0]    slot_reg, slot_next;
    logic [DBITS-1:0]    cand_reg, cand_next;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [FILL_W-1:0]   fill_reg, fill_next;
    logic                end_pend_reg, end_pend_next;
    logic                ob_valid_reg, ob_valid_next;
    logic [SYM_W-1:0]    ob_byte_reg, ob_byte_next;
    logic                ob_last_reg, ob_last_next;

    logic [DBITS-1:0]    hash_q;
    logic [ENT_W-1:0]    dict_q;
    logic [HBITS-1:0]    hash_raddr;
    logic [DBITS-1:0]    dict_raddr;
    logic                hash_we;
    logic                dict_we;

    logic [CFG_W-1:0]    held_in;
    logic [SYM_W-1:0]    sym_in;
    logic [SYM_W-1:0]    sym_mask;
    logic [NEXT_W-1:0]   clear_code;
    logic [HBITS-1:0]    hash_in;
    logic [PAIR_W-1:0]   pair;
    logic                cand_ok;
    logic                push;
    logic [CODE_W-1:0]   push_code;
    logic [NEXT_W-1:0]   next_inc;
    logic                ob_free;
    logic                can_drain;
    logic                accept;

    // Configuration register, always ready.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= MIN_SIZE_RST;
        end
        else if (cfg.valid)
        begin
            cfg_reg <= cfg.min_code_size;
        end
    end

    // Symbol masking and hashing of the incoming pixel.
    always_comb
    begin
        if (cfg_reg < MIN_SIZE_LO)
        begin
            held_in = MIN_SIZE_LO;
        end
        else if (cfg_reg > MIN_SIZE_HI)
        begin
            held_in = MIN_SIZE_HI;
        end
        else
        begin
            held_in = cfg_reg;
        end
    end

    assign sym_mask   = SYM_W'((9'd1 << (in_image_reg ? held_reg : held_in)) - 9'd1);
    assign sym_in     = pixels.pixel_index & sym_mask;
    assign clear_code = NEXT_W'(1) << held_reg;
    assign hash_in    = HBITS'((ACC_W'(prefix_reg)) ^ (ACC_W'(sym_in) << (HBITS - SYM_W)));
    assign pair       = {prefix_reg, sym_reg};
    assign cand_ok    = (NEXT_W'(hash_q) >= clear_code + NEXT_W'(2))
                        && (NEXT_W'(hash_q) < next_code_reg);
    assign accept     = pixels.valid && pixels.ready;
    assign pixels.ready = (state_reg == S_IDLE);
    assign next_inc   = next_code_reg + NEXT_W'(1);

    // Synchronous memories with registered read data.
    always_ff @(posedge clk)
    begin
        hash_q <= hash_mem[hash_raddr];
        dict_q <= dict_mem[dict_raddr];
        if (hash_we)
        begin
            hash_mem[slot_reg] <= next_code_reg[DBITS-1:0];
        end
        if (dict_we)
        begin
            dict_mem[next_code_reg[DBITS-1:0]] <= {pair, slot_reg};
        end
    end

    // Sequencer state register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            held_reg      <= MIN_SIZE_RST;
            next_code_reg <= NEXT_W'(6);
            prefix_reg    <= '0;
            width_reg     <= CWIDTH_W'(3);
            in_image_reg  <= 1'b0;
            acc_reg       <= '0;
            fill_reg      <= '0;
            end_pend_reg  <= 1'b0;
            ob_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            next_code_reg <= next_code_next;
            prefix_reg    <= prefix_next;
            width_reg     <= width_next;
            in_image_reg  <= in_image_next;
            acc_reg       <= acc_next;
            fill_reg      <= fill_next;
            end_pend_reg  <= end_pend_next;
            ob_valid_reg  <= ob_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        sym_reg     <= sym_next;
        last_reg    <= last_next;
        slot_reg    <= slot_next;
        cand_reg    <= cand_next;
        ob_byte_reg <= ob_byte_next;
        ob_last_reg <= ob_last_next;
    end

    // Next state, lookup, insert and code selection.
    always_comb
    begin
        state_next     = state_reg;
        held_next      = held_reg;
        next_code_next = next_code_reg;
        prefix_next    = prefix_reg;
        width_next     = width_reg;
        in_image_next  = in_image_reg;
        sym_next       = sym_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        cand_next      = cand_reg;
        hash_raddr     = slot_reg;
        dict_raddr     = hash_q;
        hash_we        = 1'b0;
        dict_we        = 1'b0;
        push           = 1'b0;
        push_code      = prefix_reg;
        end_pend_next  = end_pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                hash_raddr = hash_in;
                if (accept)
                begin
                    sym_next  = sym_in;
                    last_next = pixels.last_pixel;
                    slot_next = hash_in;
                    if (!in_image_reg)
                    begin
                        held_next      = held_in;
                        next_code_next = (NEXT_W'(1) << held_in) + NEXT_W'(2);
                        width_next     = held_in + CWIDTH_W'(1);
                        prefix_next    = CODE_W'(sym_in);
                        in_image_next  = 1'b1;
                        state_next     = S_EMIT_CLEAR;
                    end
                    else
                    begin
                        state_next = S_PROBE_H;
                    end
                end
            end

            S_PROBE_H:
            begin
                cand_next = hash_q;
                if (cand_ok)
                begin
                    state_next = S_PROBE_D;
                end
                else
                begin
                    state_next = S_EMIT_PREFIX;
                end
            end

            S_PROBE_D:
            begin
                if (dict_q == {pair, slot_reg})
                begin
                    prefix_next = CODE_W'(cand_reg);
                    state_next  = last_reg ? S_EMIT_LAST : S_IDLE;
                end
                else if (dict_q[HBITS-1:0] == slot_reg)
                begin
                    // The slot is taken by another pair: try the next one.
                    slot_next  = slot_reg + HBITS'(1);
                    hash_raddr = slot_reg + HBITS'(1);
                    state_next = S_PROBE_H;
                end
                else
                begin
                    // A stale code from an earlier image: the slot is free.
                    state_next = S_EMIT_PREFIX;
                end
            end

            S_EMIT_CLEAR:
            begin
                push_code = CODE_W'(clear_code);
                if (fill_reg < FILL_W'(8))
                begin
                    push       = 1'b1;
                    state_next = last_reg ? S_EMIT_LAST : S_IDLE;
                end
            end

            S_EMIT_PREFIX:
            begin
                push_code = prefix_reg;
                if (fill_reg < FILL_W'(8))
                begin
                    push = 1'b1;
                    if (next_code_reg < LIMIT_N)
                    begin
                        hash_we        = 1'b1;
                        dict_we        = 1'b1;
                        next_code_next = next_inc;
                        if ((next_inc > (NEXT_W'(1) << width_reg)) && (width_reg < MAX_CW))
                        begin
                            width_next = width_reg + CWIDTH_W'(1);
                        end
                    end
                    prefix_next = CODE_W'(sym_reg);
                    state_next  = last_reg ? S_EMIT_LAST : S_IDLE;
                end
            end

            S_EMIT_LAST:
            begin
                push_code = prefix_reg;
                if (fill_reg < FILL_W'(8))
                begin
                    push       = 1'b1;
                    state_next = S_EMIT_END;
                end
            end

            S_EMIT_END:
            begin
                push_code = CODE_W'(clear_code + NEXT_W'(1));
                if (fill_reg < FILL_W'(8))
                begin
                    push          = 1'b1;
                    end_pend_next = 1'b1;
                    in_image_next = 1'b0;
                    state_next    = S_FLUSH;
                end
            end

            S_FLUSH:
            begin
                if (!end_pend_reg)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Bit packer and output register: a code is added only below one byte of fill,
        // so adding and draining never fall in the same cycle.
        acc_next      = acc_reg;
        fill_next     = fill_reg;
        ob_valid_next = ob_valid_reg && !bytes.ready;
        ob_byte_next  = ob_byte_reg;
        ob_last_next  = ob_last_reg;
        ob_free       = !ob_valid_reg || bytes.ready;
        can_drain     = (fill_reg >= FILL_W'(8)) || (end_pend_reg && (fill_reg != '0));

        if (push)
        begin
            acc_next  = acc_reg
                        | (ACC_W'(push_code & CODE_W'((13'd1 << width_reg) - 13'd1))
                           << fill_reg);
            fill_next = fill_reg + FILL_W'(width_reg);
        end
        else if (can_drain && ob_free)
        begin
            ob_valid_next = 1'b1;
            ob_byte_next  = acc_reg[SYM_W-1:0];
            ob_last_next  = end_pend_reg && (fill_reg <= FILL_W'(8));
            acc_next      = acc_reg >> SYM_W;
            fill_next     = (fill_reg >= FILL_W'(8)) ? fill_reg - FILL_W'(8) : '0;
            if (end_pend_reg && (fill_reg <= FILL_W'(8)))
            begin
                end_pend_next = 1'b0;
            end
        end
    end

    assign bytes.valid     = ob_valid_reg;
    assign bytes.code_byte = ob_byte_reg;
    assign bytes.last_byte = ob_last_reg;

endmodule

### test/gif_lzw_compressor_checker.sv
`timescale 1ns / 100ps
// Checker for the GIF LZW compressor: watches pixel, byte and configuration beats,
// predicts the packed code bytes and compares them. Depends on glz_pkg and glz_if.sv.
module gif_lzw_compressor_checker
    import glz_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    glz_pix_if         pixels,
    glz_byte_if        bytes,
    glz_cfg_if         cfg,
    output int         failures,
    output int         bytes_pending
);

    localparam int DEPTH = DICT_DEPTH_DEF;
    localparam int MAX_BITS = MAX_CODE_BITS_DEF;

    typedef struct packed {
        logic [SYM_W-1:0] code_byte;
        logic             last_byte;
    } packed_byte_t;

    packed_byte_t expected_bytes[$];

    // Predictor state.
    logic [PAIR_W-1:0]   pairs [DEPTH];
    logic [NEXT_W-1:0]   free_code;
    logic [CODE_W-1:0]   prefix;
    logic [CWIDTH_W-1:0] width;
    logic [7:0]          acc;
    int                  fill;
    logic                open_image;
    logic [CFG_W-1:0]    size_reg;
    int                  size_held;

    assign bytes_pending = expected_bytes.size();

    // Appends one code to the bit packer, pushing each completed byte.
    task automatic pack_code(input int code, input int w);
        for (int b = 0; b < w; b++)
        begin
            acc[fill] = 1'((code >> b) & 1);
            fill++;
            if (fill == 8)
            begin
                expected_bytes.push_back('{acc, 1'b0});
                acc = '0;
                fill = 0;
            end
        end
    endtask

    // Works out the bytes caused by one pixel beat.
    task automatic encode_pixel(input logic [SYM_W-1:0] pix, input logic last);
        int clear_code;
        int sym;
        int hit;
        int n0;
        logic [PAIR_W-1:0] pair;
        n0 = expected_bytes.size();
        hit = -1;
        if (!open_image)
        begin
            size_held = size_reg < 2 ? 2 : (size_reg > 8 ? 8 : int'(size_reg));
            clear_code = 1 << size_held;
            free_code = NEXT_W'(clear_code + 2);
            width = CWIDTH_W'(size_held + 1);
            sym = int'(pix) & (clear_code - 1);
            pack_code(clear_code, int'(width));
            prefix = CODE_W'(sym);
            open_image = 1'b1;
        end
        else
        begin
            clear_code = 1 << size_held;
            sym = int'(pix) & (clear_code - 1);
            pair = {prefix, 8'(sym)};
            for (int c = clear_code + 2; c < free_code && c < DEPTH; c++)
            begin
                if (pairs[c] == pair)
                begin
                    hit = c;
                    break;
                end
            end
            if (hit >= 0)
                prefix = CODE_W'(hit);
            else
            begin
                pack_code(int'(prefix), int'(width));
                if (free_code < DEPTH)
                begin
                    pairs[free_code] = pair;
                    free_code++;
                    if (free_code > (1 << width) && width < MAX_BITS)
                        width++;
                end
                prefix = CODE_W'(sym);
            end
        end
        if (last)
        begin
            pack_code(int'(prefix), int'(width));
            pack_code(clear_code + 1, int'(width));
            if (fill != 0)
            begin
                expected_bytes.push_back('{acc, 1'b0});
                acc = '0;
                fill = 0;
            end
            if (expected_bytes.size() > n0)
                expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
            open_image = 1'b0;
        end
    endtask

    // Follows the beats at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        if (!rst_n)
        begin
            expected_bytes.delete();
            free_code = NEXT_W'(6);
            prefix = '0;
            width = CWIDTH_W'(3);
            acc = '0;
            fill = 0;
            open_image = 1'b0;
            size_reg = MIN_SIZE_RST;
            size_held = 2;
            failures = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                size_reg = cfg.min_code_size;
            if (pixels.valid && pixels.ready)
                encode_pixel(pixels.pixel_index, pixels.last_pixel);
            if (bytes.valid && bytes.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Unexpected byte beat: %h last %b",
                                 bytes.code_byte, bytes.last_byte);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (want.code_byte !== bytes.code_byte
                        || want.last_byte !== bytes.last_byte)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("Byte mismatch: expected %h/%b, got %h/%b",
                                     want.code_byte, want.last_byte,
                                     bytes.code_byte, bytes.last_byte);
                    end
                end
            end
        end
    end

endmodule

### test/gif_lzw_compressor_test.sv
`timescale 1ns / 100ps
// Testbench top for the GIF LZW compressor: clock, reset, pixel and configuration
// stimulus and the verdict. Depends on glz_pkg, glz_if.sv and the checker module.
module gif_lzw_compressor_test;
    import glz_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic clk;
    logic rst_n;
    int   failures;
    int   bytes_pending;
    int   cycles;
    logic calm;

    glz_pix_if  pixels();
    glz_byte_if bytes();
    glz_cfg_if  cfg();

    gif_lzw_compressor uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixels (pixels),
        .bytes  (bytes),
        .cfg    (cfg)
    );

    gif_lzw_compressor_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .pixels        (pixels),
        .bytes         (bytes),
        .cfg           (cfg),
        .failures      (failures),
        .bytes_pending (bytes_pending)
    );

    // Clock with a 12 ns period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Random byte receiver stalls, none while the calm stretch runs.
    always @(negedge clk)
    begin
        if (!rst_n)
            bytes.ready <= 1'b0;
        else
            bytes.ready <= calm || ($urandom_range(99) >= 7);
    end

    // Watchdog on the cycle count.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Sends one pixel beat, idling at random beforehand. The beat is left driven;
    // the next pixel or a drain takes it over at the following falling edge.
    task automatic send_pixel(input logic [SYM_W-1:0] pix, input logic last);
        if (!calm && $urandom_range(99) < 7)
        begin
            pixels.valid <= 1'b0;
            do
                @(negedge clk);
            while (!calm && $urandom_range(99) < 7);
        end
        pixels.valid <= 1'b1;
        pixels.pixel_index <= pix;
        pixels.last_pixel <= last;
        @(posedge clk);
        while (!pixels.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending, waits for every expected byte, then lets the block settle.
    task automatic drain();
        pixels.valid <= 1'b0;
        while (bytes_pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // Writes the minimum code size while the block is idle.
    task automatic write_size(input logic [CFG_W-1:0] value);
        drain();
        cfg.valid <= 1'b1;
        cfg.min_code_size <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    // One image of n pixels; repetitive content grows dictionary matches.
    task automatic send_image(input int n, input int alphabet);
        int span;
        for (int i = 0; i < n; i++)
        begin
            span = $urandom_range(9);
            send_pixel(span < 6 ? 8'($urandom_range(alphabet - 1)) : 8'($urandom),
                       i == n - 1);
        end
    endtask

    initial
    begin
        int sizes[5] = '{2, 8, 5, 0, 15};
        cycles = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        pixels.valid = 1'b0;
        pixels.pixel_index = '0;
        pixels.last_pixel = 1'b0;
        cfg.valid = 1'b0;
        cfg.min_code_size = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: single-pixel images, extremes of the pixel field, repeats.
        send_pixel(8'h00, 1'b1);
        send_pixel(8'hFF, 1'b1);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'h03, 1'b0);
        send_pixel(8'hFC, 1'b1);
        write_size(4'd8);
        send_pixel(8'hFF, 1'b0);
        send_pixel(8'h00, 1'b0);
        send_pixel(8'hAA, 1'b0);
        send_pixel(8'h55, 1'b1);
        // A write in the middle of an image takes effect at the next one.
        write_size(4'd3);
        send_pixel(8'h07, 1'b0);
        drain();
        cfg.valid <= 1'b1;
        cfg.min_code_size <= 4'd6;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        send_pixel(8'h3F, 1'b1);
        write_size(4'd1);
        send_pixel(8'h02, 1'b0);
        send_pixel(8'h01, 1'b1);

        // A longer image with a four-symbol alphabet grows the code width, sent
        // with no idling on either side.
        write_size(4'd2);
        calm = 1'b1;
        for (int i = 0; i < 60; i++)
            send_pixel(8'($urandom_range(3)), i == 59);
        calm = 1'b0;

        // Random images across the sizes, with a pause for the bytes to arrive.
        for (int k = 0; k < 20; k++)
        begin
            write_size(4'(k < 5 ? sizes[k] : $urandom_range(15)));
            if (k == 10)
                calm = 1'b1;
            if (k == 13)
                calm = 1'b0;
            send_image($urandom_range(1, 30), $urandom_range(1, 4));
        end

        drain();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
